// File: src/scaled_log_forward_backward_unit_defines.svh
// assertion helpers used by the top-level RTL
`ifndef SCALED_LOG_FORWARD_BACKWARD_UNIT_DEFINES_SVH
`define SCALED_LOG_FORWARD_BACKWARD_UNIT_DEFINES_SVH

// same-cycle implication
`define SLFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/slfb_pkg.sv
`timescale 1ns / 1ps
package slfb_pkg;
	localparam int LOG_FRAC   = 30;
	localparam int LN_FRAC    = 24;
	localparam int QUO_BITS   = 33;
	localparam int MID_STAGES = 34;
	localparam logic signed [24:0] LN2_FIX = 25'sd11629080;

	localparam logic [1:0] REG_IN_SCALE   = 2'd0;
	localparam logic [1:0] REG_IN_SHIFT   = 2'd1;
	localparam logic [1:0] REG_OUT_SCALE  = 2'd2;
	localparam logic [1:0] REG_GRAD_SCALE = 2'd3;

	typedef struct packed {
		logic mode;
		logic tpos;
		logic gneg;
		logic gzero;
	} side_t;
endpackage

// File: src/scaled_log_forward_backward_unit.sv
// channel   | handshake                 | payload
// sample    | sample_valid/sample_stall | mode, sample, grad_in
// result    | result_valid/result_stall | value_out, domain_error
// config    | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// Fully pipelined: one transaction per cycle while the result channel is not stalled.
// Latency is set by the 30-stage log2 squaring chain and the 33-stage
// quotient chain, which run side by side.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipe; sample_stall follows result_stall
// only while the output register holds a result.
`timescale 1ns / 1ps
`include "scaled_log_forward_backward_unit_defines.svh"
module scaled_log_forward_backward_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic               mode,
	input  logic signed [31:0] sample,
	input  logic signed [31:0] grad_in,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] value_out,
	output logic               domain_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int MS = slfb_pkg::MID_STAGES;
	localparam int LN = slfb_pkg::LN_FRAC;

	logic signed [31:0] in_scale_q, in_shift_q, out_scale_q, grad_scale_q;
	logic en;

	assign cfg_ready    = 1'b1;
	assign en           = !result_valid || !result_stall;
	assign sample_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scale_q   <= 32'(64'd1 << FRAC_BITS);
			in_shift_q   <= '0;
			out_scale_q  <= 32'(64'd1 << FRAC_BITS);
			grad_scale_q <= 32'(64'd1 << FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slfb_pkg::REG_IN_SCALE:   in_scale_q   <= cfg_data;
				slfb_pkg::REG_IN_SHIFT:   in_shift_q   <= cfg_data;
				slfb_pkg::REG_OUT_SCALE:  out_scale_q  <= cfg_data;
				slfb_pkg::REG_GRAD_SCALE: grad_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic               vld_s1, vld_s2, mode_s1, mode_s2;
	logic signed [63:0] prod_s1, g_s1, t_s2, g_s2;
	logic [MS-1:0]      mid_vld_s;
	slfb_pkg::side_t    mid_side_s[MS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			mid_vld_s <= '0;
		end else if (en) begin
			vld_s1    <= sample_valid;
			vld_s2    <= vld_s1;
			mid_vld_s <= {mid_vld_s[MS-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= in_scale_q * sample;
			g_s1    <= grad_in * grad_scale_q;
			mode_s1 <= mode;
			t_s2    <= prod_s1 + (64'(in_shift_q) <<< FRAC_BITS);
			g_s2    <= g_s1;
			mode_s2 <= mode_s1;
			mid_side_s[0] <= '{mode: mode_s2,
			                   tpos: !t_s2[63] && (t_s2 != '0),
			                   gneg: g_s2[63],
			                   gzero: g_s2 == '0};
			for (int i = 1; i < MS; i++) mid_side_s[i] <= mid_side_s[i-1];
		end
	end

	logic signed [63:0]            log_prod;
	logic [slfb_pkg::QUO_BITS-1:0] quo;
	logic                          quo_hi;

	slfb_log #(.FRAC_BITS(FRAC_BITS)) u_log (
		.clk       (clk),
		.en        (en),
		.t         (t_s2),
		.out_scale (out_scale_q),
		.prod      (log_prod)
	);

	slfb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk (clk),
		.en  (en),
		.t   (t_s2),
		.g   (g_s2),
		.quo (quo),
		.hi  (quo_hi)
	);

	slfb_pkg::side_t side;
	logic signed [63:0] fp, fv;
	logic [slfb_pkg::QUO_BITS-1:0] lim, bmag;
	logic        f_ov, b_ov, res_err;
	logic [31:0] res_val;

	always_comb begin
		side = mid_side_s[MS-1];
		fp   = log_prod + (64'sd1 <<< (LN - 1));
		fv   = fp >>> LN;
		f_ov = !((&fv[63:31]) || !(|fv[63:31]));
		lim  = side.gneg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		b_ov = quo_hi || (quo > lim);
		bmag = b_ov ? lim : quo;
		if (!side.mode) begin
			if (!side.tpos) begin
				res_err = 1'b1;
				res_val = out_scale_q > 0 ? 32'h8000_0000 :
				          (out_scale_q < 0 ? 32'h7FFF_FFFF : 32'h0);
			end else begin
				res_err = f_ov;
				res_val = f_ov ? (fv[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : fv[31:0];
			end
		end else begin
			if (!side.tpos) begin
				res_err = 1'b1;
				res_val = side.gzero ? 32'h0 :
				          (side.gneg ? 32'h8000_0000 : 32'h7FFF_FFFF);
			end else begin
				res_err = b_ov;
				res_val = side.gneg ? 32'(-bmag) : bmag[31:0];
			end
		end
	end

	logic        vld_s37, err_s37;
	logic [31:0] value_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s37 <= 1'b0;
		end else if (en) begin
			vld_s37 <= mid_vld_s[MS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s37 <= res_val;
			err_s37   <= res_err;
		end
	end

	assign result_valid = vld_s37;
	assign value_out    = value_s37;
	assign domain_error = err_s37;

	`SLFB_ASSERT_NEXT(a_enter, clk, arst_n, sample_valid && !sample_stall, vld_s1, "accepted sample lost at entry")
	`SLFB_ASSERT_NEXT(a_freeze, clk, arst_n, !en, $stable(mid_vld_s), "pipe moved while stalled")
	`SLFB_ASSERT_NEXT(a_bad_t, clk, arst_n, en && mid_vld_s[MS-1] && !mid_side_s[MS-1].tpos, domain_error, "nonpositive t not flagged")
	`SLFB_ASSERT_SAME(a_stall, clk, arst_n, result_valid && result_stall, sample_stall, "entry open while output blocked")
endmodule

// File: src/slfb_log.sv
`timescale 1ns / 1ps
module slfb_log #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] t,
	input  logic signed [31:0] out_scale,
	output logic signed [63:0] prod
);
	localparam int LF = slfb_pkg::LOG_FRAC;

	logic [2:0]  bsel;
	logic [2:0]  byte_s3;
	logic [63:0] sh_s3;

	always_comb begin
		bsel = '0;
		for (int i = 1; i < 8; i++) begin
			if (|t[8*i +: 8]) bsel = 3'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s3 <= bsel;
			sh_s3   <= t << (6'(3'd7 - bsel) << 3);
		end
	end

	// fine normalize inside the top byte
	logic [2:0]  psel;
	logic [63:0] sh_fine;
	logic [31:0] m_s[LF+1];
	logic [LF-1:0] frac_s[LF+1];
	logic [5:0]  n_s[LF+1];

	always_comb begin
		psel = '0;
		for (int i = 0; i < 8; i++) begin
			if (sh_s3[56+i]) psel = 3'(i);
		end
		sh_fine = sh_s3 << (3'd7 - psel);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= sh_fine[63:32];
			frac_s[0] <= '0;
			n_s[0]    <= {byte_s3, psel};
		end
	end

	// one squaring per stage, one fraction bit each
	for (genvar j = 0; j < LF; j++) begin : g_sq
		logic [63:0] sq;
		assign sq = m_s[j] * m_s[j];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[j+1]    <= sq[63] ? sq[63:32] : sq[62:31];
				frac_s[j+1] <= {frac_s[j][LF-2:0], sq[63]};
				n_s[j+1]    <= n_s[j];
			end
		end
	end

	logic signed [7:0]  nd;
	logic signed [37:0] l2;
	logic signed [62:0] lp;
	logic signed [31:0] ln_s35;
	logic signed [63:0] prod_s36;

	assign nd = $signed({2'b00, n_s[LF]}) - $signed(8'(2 * FRAC_BITS));
	assign l2 = {nd, frac_s[LF]};
	assign lp = l2 * slfb_pkg::LN2_FIX;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s35   <= lp[LF+31:LF];
			prod_s36 <= out_scale * ln_s35;
		end
	end

	assign prod = prod_s36;
endmodule

// File: src/slfb_div.sv
`timescale 1ns / 1ps
module slfb_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [63:0]            t,
	input  logic signed [63:0]            g,
	output logic [slfb_pkg::QUO_BITS-1:0] quo,
	output logic                          hi
);
	localparam int QB = slfb_pkg::QUO_BITS;
	localparam int RW = 63 + QB;

	logic [62:0]   mag;
	logic [RW-1:0] num;
	logic [RW-1:0] dd;
	logic [RW-1:0] r_s[QB+1];
	logic [RW-1:0] d_s[QB+1];
	logic [QB-1:0] q_s[QB+1];
	logic          hi_s[QB+1];

	assign mag = g[63] ? 63'(-g) : g[62:0];
	assign num = RW'(mag) << FRAC_BITS;
	assign dd  = RW'(t[62:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]  <= num;
			d_s[0]  <= dd;
			q_s[0]  <= '0;
			hi_s[0] <= num >= (dd << QB);
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int K = QB - 1 - j;
		logic [RW-1:0] ds;
		logic          ge;
		assign ds = d_s[j] << K;
		assign ge = r_s[j] >= ds;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j+1]  <= ge ? r_s[j] - ds : r_s[j];
				d_s[j+1]  <= d_s[j];
				q_s[j+1]  <= {q_s[j][QB-2:0], ge};
				hi_s[j+1] <= hi_s[j];
			end
		end
	end

	assign quo = q_s[QB];
	assign hi  = hi_s[QB];
endmodule
